FILE: rtl/fsrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame slot ring manager package
// Request codes, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fsrm_pkg;

    typedef enum logic [2:0] {
        REQ_CLAIM_WR  = 3'd0,
        REQ_DONE_WR   = 3'd1,
        REQ_CLAIM_RD  = 3'd2,
        REQ_CLAIM_LAT = 3'd3,
        REQ_DONE_RD   = 3'd4,
        REQ_FLUSH     = 3'd5,
        REQ_TICK      = 3'd6
    } req_t;

    localparam logic CFG_NUM_SLOTS  = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOKUP,
        ST_SWEEP
    } st_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;     // capture the input beat
        logic rd_issue;     // read slot length and stamp
        logic sweep_start;  // clear the flush step counter
        logic sweep_step;   // clear one fresh mark and advance the read index
        logic commit;       // apply the request and load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] req;
        logic       out_free;
        logic       sweep_done;
    } sts_t;

endpackage : fsrm_pkg
`default_nettype wire

FILE: rtl/frame_slot_ring_manager_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame slot ring manager
// Slot bookkeeping for a ring of frame buffers shared by one writer and one
// reader: claim and finish writes, claim oldest or latest for reading,
// release, flush and tick. Payload storage lives outside this block.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat content
//  -------  ---------  --------------------------------------------------------
//  s_*      in         one request: type, length, stamp select, stamp
//  m_*      out        one result per request: status, slot, length, stamp,
//                      packets left, busy
//  cfg_*    in         register write: 0 num_slots, 1 max_length
//
//  Sequencing: one request at a time. Write, release and tick requests pass
//  through capture and execute; read claims add a lookup state for the
//  registered read of the slot length and stamp stores. Flush adds a walk of
//  one step per slot, at most MAX_SLOTS + 1 steps.
//  Reset clears indexes, flags, fresh marks, tick count and store valid bits.
//  A stalled result holds in the output register; the next request is taken
//  meanwhile and waits in its last state until that register frees up.
//
module frame_slot_ring_manager_unit #(
    parameter int MAX_SLOTS  = 16,
    parameter int MAX_LEN    = 4096,
    parameter int STAMP_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [12:0] frame_length, [44:13] stamp_in, rest zero
    input  wire logic [3:0]  s_tuser,   // [2:0] req_type, [3] stamp_given
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [3:0] slot_index, [16:4] slot_length,
                                        // [48:17] slot_stamp, [52:49] packets_left,
                                        // [53] busy_res, rest zero
    output logic [0:0]       m_tuser,   // [0] status
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [12:0] cfg_data
);

    fsrm_pkg::cmd_t cmd;
    fsrm_pkg::sts_t sts;

    logic        res_status;
    logic [3:0]  res_slot;
    logic [12:0] res_length;
    logic [31:0] res_stamp;
    logic [3:0]  res_left;
    logic        res_busy;

    // sequence capture, execute, lookup and flush walk
    fsrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ring state, slot stores and the result register
    fsrm_dpath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_LEN    (MAX_LEN),
        .STAMP_BITS (STAMP_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .in_req_type      (s_tuser[2:0]),
        .in_frame_length  (s_tdata[12:0]),
        .in_stamp_given   (s_tuser[3]),
        .in_stamp         (s_tdata[44:13]),
        .cmd              (cmd),
        .sts              (sts),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_status       (res_status),
        .out_slot_index   (res_slot),
        .out_slot_length  (res_length),
        .out_slot_stamp   (res_stamp),
        .out_packets_left (res_left),
        .out_busy         (res_busy)
    );

    // pack the result beat, highest field first
    assign m_tdata = {2'b00, res_busy, res_left, res_stamp, res_length, res_slot};
    assign m_tuser = res_status;

endmodule : frame_slot_ring_manager_unit
`default_nettype wire

FILE: rtl/fsrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fsrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : fsrm_ram
`default_nettype wire

FILE: rtl/fsrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame slot ring manager controller
// Sequences one request at a time: capture, execute, slot lookup or flush walk.
// ----------------------------------------------------------------------------
module fsrm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fsrm_pkg::sts_t sts,
    output fsrm_pkg::cmd_t     cmd
);

    fsrm_pkg::st_t state_reg;
    fsrm_pkg::st_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsrm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            fsrm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = fsrm_pkg::ST_EXEC;
                end
            end
            fsrm_pkg::ST_EXEC:
            begin
                case (sts.req)
                    fsrm_pkg::REQ_CLAIM_RD,
                    fsrm_pkg::REQ_CLAIM_LAT:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = fsrm_pkg::ST_LOOKUP;
                    end
                    fsrm_pkg::REQ_FLUSH:
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = fsrm_pkg::ST_SWEEP;
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.commit = 1'b1;
                            state_next = fsrm_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            fsrm_pkg::ST_LOOKUP:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = fsrm_pkg::ST_IDLE;
                end
            end
            fsrm_pkg::ST_SWEEP:
            begin
                if (!sts.sweep_done)
                begin
                    cmd.sweep_step = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = fsrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fsrm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule : fsrm_ctrl
`default_nettype wire

FILE: rtl/fsrm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame slot ring manager datapath
// Ring indexes, open flags, fresh marks, slot length and stamp stores,
// tick counter, configuration and the result register.
// ----------------------------------------------------------------------------
module fsrm_dpath #(
    parameter int MAX_SLOTS  = 16,
    parameter int MAX_LEN    = 4096,
    parameter int STAMP_BITS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // configuration
    input  wire logic           cfg_we,
    input  wire logic           cfg_addr,
    input  wire logic [12:0]    cfg_data,
    // request fields
    input  wire logic [2:0]     in_req_type,
    input  wire logic [12:0]    in_frame_length,
    input  wire logic           in_stamp_given,
    input  wire logic [31:0]    in_stamp,
    // control
    input  wire fsrm_pkg::cmd_t cmd,
    output fsrm_pkg::sts_t      sts,
    // result
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic                out_status,
    output logic [3:0]          out_slot_index,
    output logic [12:0]         out_slot_length,
    output logic [31:0]         out_slot_stamp,
    output logic [3:0]          out_packets_left,
    output logic                out_busy
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int SZ_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int PW    = SZ_W + 2;
    localparam int SWP_W = $clog2(MAX_SLOTS + 2);
    localparam int LLW0  = $clog2(MAX_LEN + 1);
    localparam int LIM_W = (LLW0 > 13) ? LLW0 : 13;
    localparam int STW   = (STAMP_BITS > 32) ? STAMP_BITS : 32;
    localparam int SLW   = (IDX_W > 4) ? IDX_W : 4;

    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
                                            input logic [SZ_W-1:0] n);
        logic [SZ_W-1:0] nx;
        nx = SZ_W'(i) + SZ_W'(1);
        return (nx >= n) ? '0 : nx[IDX_W-1:0];
    endfunction

    // configuration
    logic [4:0]  num_slots_reg;
    logic [12:0] max_length_reg;

    // captured request
    logic [2:0]  req_reg;
    logic [12:0] len_reg;
    logic        given_reg;
    logic [31:0] stamp_in_reg;

    // ring state
    logic [IDX_W-1:0]      w_reg,     w_next;
    logic [IDX_W-1:0]      r_reg,     r_next;
    logic                  wopen_reg, wopen_next;
    logic                  ropen_reg, ropen_next;
    logic                  lval_reg,  lval_next;
    logic [IDX_W-1:0]      lidx_reg,  lidx_next;
    logic [MAX_SLOTS-1:0]  fresh_reg, fresh_next;
    logic [STAMP_BITS-1:0] tick_reg,  tick_next;
    logic [MAX_SLOTS-1:0]  len_vld_reg, len_vld_next;
    logic [MAX_SLOTS-1:0]  stp_vld_reg, stp_vld_next;
    logic [SWP_W-1:0]      swp_cnt_reg;
    logic                  rlen_vld_reg;
    logic                  rstp_vld_reg;

    // result register
    logic        out_valid_reg;
    logic        status_reg;
    logic [3:0]  slot_reg;
    logic [12:0] olen_reg;
    logic [31:0] ostamp_reg;
    logic [3:0]  left_reg;
    logic        busy_reg;

    // derived values
    logic [SZ_W-1:0]       ring_n;
    logic [LIM_W-1:0]      len_limit;
    logic                  len_ok;
    logic [IDX_W-1:0]      w_adv;
    logic [IDX_W-1:0]      r_adv;
    logic [PW-1:0]         pd0;
    logic [PW-1:0]         pd1;
    logic [3:0]            pkt_left;
    logic [STW-1:0]        stamp_wide;
    logic [STAMP_BITS-1:0] stamp_wr;
    logic [IDX_W-1:0]      rd_addr;
    logic [12:0]           len_rdata;
    logic [STAMP_BITS-1:0] stp_rdata;
    logic [12:0]           rd_len;
    logic [STW-1:0]        rd_stamp_wide;
    logic                  len_we;
    logic                  stp_we;

    // result fields of the current commit
    logic             res_status;
    logic [IDX_W-1:0] res_slot;
    logic [SLW-1:0]   res_slot_wide;
    logic [12:0]      res_len;
    logic [31:0]      res_stamp;
    logic [3:0]       res_left;

    always_comb
    begin
        if (num_slots_reg == 5'd0)
        begin
            ring_n = SZ_W'(1);
        end
        else if (SZ_W'(num_slots_reg) > SZ_W'(MAX_SLOTS))
        begin
            ring_n = SZ_W'(MAX_SLOTS);
        end
        else
        begin
            ring_n = SZ_W'(num_slots_reg);
        end
    end

    always_comb
    begin
        if (LIM_W'(max_length_reg) > LIM_W'(MAX_LEN))
        begin
            len_limit = LIM_W'(MAX_LEN);
        end
        else
        begin
            len_limit = LIM_W'(max_length_reg);
        end
    end

    assign len_ok = (LIM_W'(len_reg) <= len_limit);
    assign w_adv  = adv(w_reg, ring_n);
    assign r_adv  = adv(r_reg, ring_n);

    // frames queued behind the open read slot
    always_comb
    begin
        pd0 = PW'(w_reg) - PW'(r_reg) - PW'(1);
        pd1 = pd0[PW-1] ? (pd0 + PW'(ring_n)) : pd0;
        pkt_left = pd1[PW-1] ? 4'd0 : pd1[3:0];
    end

    assign stamp_wide = STW'(stamp_in_reg);
    assign stamp_wr   = given_reg ? stamp_wide[STAMP_BITS-1:0] : tick_reg;

    // slot stores; an entry never written reads as zero
    assign rd_addr = (req_reg == fsrm_pkg::REQ_CLAIM_LAT) ? lidx_reg : r_reg;

    fsrm_ram #(.WIDTH(13), .DEPTH(MAX_SLOTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (w_reg),
        .wdata (len_reg),
        .re    (cmd.rd_issue),
        .raddr (rd_addr),
        .rdata (len_rdata)
    );

    fsrm_ram #(.WIDTH(STAMP_BITS), .DEPTH(MAX_SLOTS)) u_stamp_ram (
        .clk   (clk),
        .we    (stp_we),
        .waddr (w_reg),
        .wdata (stamp_wr),
        .re    (cmd.rd_issue),
        .raddr (rd_addr),
        .rdata (stp_rdata)
    );

    assign rd_len        = rlen_vld_reg ? len_rdata : 13'd0;
    assign rd_stamp_wide = rstp_vld_reg ? STW'(stp_rdata) : '0;

    // next state for one flush step or one committed request
    always_comb
    begin
        w_next       = w_reg;
        r_next       = r_reg;
        wopen_next   = wopen_reg;
        ropen_next   = ropen_reg;
        lval_next    = lval_reg;
        lidx_next    = lidx_reg;
        fresh_next   = fresh_reg;
        tick_next    = tick_reg;
        len_vld_next = len_vld_reg;
        stp_vld_next = stp_vld_reg;
        len_we       = 1'b0;
        stp_we       = 1'b0;
        res_status   = 1'b1;
        res_slot     = '0;
        res_len      = 13'd0;
        res_stamp    = 32'd0;
        res_left     = 4'd0;
        if (cmd.sweep_step)
        begin
            fresh_next[r_reg] = 1'b0;
            r_next            = r_adv;
        end
        else if (cmd.commit)
        begin
            case (req_reg)
                fsrm_pkg::REQ_CLAIM_WR:
                begin
                    if (!wopen_reg)
                    begin
                        if (w_reg == r_reg && ropen_reg)
                        begin
                            w_next = w_adv;
                        end
                        wopen_next = 1'b1;
                        res_slot   = (w_reg == r_reg && ropen_reg) ? w_adv : w_reg;
                        res_status = 1'b0;
                    end
                end
                fsrm_pkg::REQ_DONE_WR:
                begin
                    if (wopen_reg && len_ok)
                    begin
                        len_we              = 1'b1;
                        len_vld_next[w_reg] = 1'b1;
                        res_slot            = w_reg;
                        if (len_reg != 13'd0)
                        begin
                            fresh_next[w_reg]   = 1'b1;
                            stp_we              = 1'b1;
                            stp_vld_next[w_reg] = 1'b1;
                            lval_next           = 1'b1;
                            lidx_next           = w_reg;
                            w_next              = w_adv;
                        end
                        else
                        begin
                            fresh_next[w_reg] = 1'b0;
                        end
                        wopen_next = 1'b0;
                        res_status = 1'b0;
                    end
                end
                fsrm_pkg::REQ_CLAIM_RD:
                begin
                    if (!ropen_reg && r_reg != w_reg)
                    begin
                        fresh_next[r_reg] = 1'b0;
                        res_slot          = r_reg;
                        res_len           = rd_len;
                        res_stamp         = rd_stamp_wide[31:0];
                        ropen_next        = 1'b1;
                        res_status        = 1'b0;
                    end
                end
                fsrm_pkg::REQ_CLAIM_LAT:
                begin
                    if (!ropen_reg && lval_reg && fresh_reg[lidx_reg])
                    begin
                        fresh_next[lidx_reg] = 1'b0;
                        r_next               = lidx_reg;
                        res_slot             = lidx_reg;
                        res_len              = rd_len;
                        res_stamp            = rd_stamp_wide[31:0];
                        ropen_next           = 1'b1;
                        res_status           = 1'b0;
                    end
                end
                fsrm_pkg::REQ_DONE_RD:
                begin
                    if (ropen_reg)
                    begin
                        res_left = pkt_left;
                        res_slot = r_reg;
                        if (r_reg != w_reg)
                        begin
                            r_next = r_adv;
                        end
                        ropen_next = 1'b0;
                        res_status = 1'b0;
                    end
                end
                fsrm_pkg::REQ_FLUSH:
                begin
                    res_status = 1'b0;
                end
                fsrm_pkg::REQ_TICK:
                begin
                    tick_next  = tick_reg + STAMP_BITS'(1);
                    res_status = 1'b0;
                end
                default:
                begin
                    res_status = 1'b1;
                end
            endcase
        end
    end

    assign res_slot_wide = SLW'(res_slot);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_slots_reg  <= 5'd16;
            max_length_reg <= 13'd4096;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == fsrm_pkg::CFG_NUM_SLOTS)
            begin
                num_slots_reg <= cfg_data[4:0];
            end
            else
            begin
                max_length_reg <= cfg_data;
            end
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg      <= in_req_type;
            len_reg      <= in_frame_length;
            given_reg    <= in_stamp_given;
            stamp_in_reg <= in_stamp;
        end
    end

    // ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= '0;
            r_reg        <= '0;
            wopen_reg    <= 1'b0;
            ropen_reg    <= 1'b0;
            lval_reg     <= 1'b0;
            lidx_reg     <= '0;
            fresh_reg    <= '0;
            tick_reg     <= '0;
            len_vld_reg  <= '0;
            stp_vld_reg  <= '0;
            swp_cnt_reg  <= '0;
            rlen_vld_reg <= 1'b0;
            rstp_vld_reg <= 1'b0;
        end
        else
        begin
            w_reg       <= w_next;
            r_reg       <= r_next;
            wopen_reg   <= wopen_next;
            ropen_reg   <= ropen_next;
            lval_reg    <= lval_next;
            lidx_reg    <= lidx_next;
            fresh_reg   <= fresh_next;
            tick_reg    <= tick_next;
            len_vld_reg <= len_vld_next;
            stp_vld_reg <= stp_vld_next;
            if (cmd.sweep_start)
            begin
                swp_cnt_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                swp_cnt_reg <= swp_cnt_reg + SWP_W'(1);
            end
            if (cmd.rd_issue)
            begin
                rlen_vld_reg <= len_vld_reg[rd_addr];
                rstp_vld_reg <= stp_vld_reg[rd_addr];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= res_status;
            slot_reg   <= res_slot_wide[3:0];
            olen_reg   <= res_len;
            ostamp_reg <= res_stamp;
            left_reg   <= res_left;
            busy_reg   <= ropen_next || (w_next != r_next);
        end
    end

    assign sts.req        = req_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.sweep_done = (r_reg == w_reg) || (swp_cnt_reg == SWP_W'(MAX_SLOTS + 1));

    assign out_valid        = out_valid_reg;
    assign out_status       = status_reg;
    assign out_slot_index   = slot_reg;
    assign out_slot_length  = olen_reg;
    assign out_slot_stamp   = ostamp_reg;
    assign out_packets_left = left_reg;
    assign out_busy         = busy_reg;

endmodule : fsrm_dpath
`default_nettype wire
